// ===== src/trq_pkg.sv =====
// ----------------------------------------------------------------------------
// trq_pkg
// Shared widths, command and status codes, and the control and status
// bundles that pass between the thread ready queue controller and datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package trq_pkg;

  // fixed field widths of the command and result words
  localparam int unsigned CMD_W    = 2;
  localparam int unsigned TID_W    = 8;
  localparam int unsigned STATUS_W = 2;

  // command codes
  localparam logic [CMD_W-1:0] CMD_ENQ  = 2'd0;
  localparam logic [CMD_W-1:0] CMD_DEQ  = 2'd1;
  localparam logic [CMD_W-1:0] CMD_REM  = 2'd2;
  localparam logic [CMD_W-1:0] CMD_NEXT = 2'd3;

  // status codes
  localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
  localparam logic [STATUS_W-1:0] ST_EMPTY    = 2'd1;
  localparam logic [STATUS_W-1:0] ST_NOTFOUND = 2'd2;
  localparam logic [STATUS_W-1:0] ST_FULL     = 2'd3;

  // controller to datapath commands
  typedef struct packed {
    logic                load;
    logic                ptr_clr;
    logic                ptr_inc;
    logic                wr_enq;
    logic                wr_shift;
    logic                cnt_inc;
    logic                cnt_dec;
    logic                head_inc;
    logic                res_wr;
    logic                res_take;
    logic [STATUS_W-1:0] res_status;
    logic                out_load;
  } trq_ctrl_t;

  // datapath to controller status
  typedef struct packed {
    logic [CMD_W-1:0] command;
    logic             full;
    logic             empty;
    logic             match;
    logic             at_end;
    logic             last;
    logic             at_head;
    logic             out_busy;
  } trq_stat_t;

endpackage

`default_nettype wire

// ===== src/trq_if.sv =====
// ----------------------------------------------------------------------------
// trq_if
// Valid/ready channels of the thread ready queue: command words in and
// result words out.
// ----------------------------------------------------------------------------
`default_nettype none

interface trq_cmd_if;
  logic                        valid;
  logic                        ready;
  logic [trq_pkg::CMD_W-1:0]   command;
  logic [trq_pkg::TID_W-1:0]   thread_id;

  modport source (output valid, output command, output thread_id, input ready);
  modport sink   (input valid, input command, input thread_id, output ready);
endinterface

interface trq_res_if;
  logic                         valid;
  logic                         ready;
  logic [trq_pkg::STATUS_W-1:0] status;
  logic [trq_pkg::TID_W-1:0]    result_id;
  logic                         now_empty;

  modport source (output valid, output status, output result_id, output now_empty,
                  input ready);
  modport sink   (input valid, input status, input result_id, input now_empty,
                  output ready);
endinterface

`default_nettype wire

// ===== src/trq_dp.sv =====
// ----------------------------------------------------------------------------
// trq_dp
// Datapath of the thread ready queue: id store, head and count registers,
// scan pointer, match compare and the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module trq_dp #(
  parameter int unsigned DEPTH   = 16,
  parameter int unsigned ID_BITS = 8
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  trq_pkg::trq_ctrl_t               ctrl_i,
  output trq_pkg::trq_stat_t               stat_o,
  input  logic [trq_pkg::CMD_W-1:0]        command_i,
  input  logic [trq_pkg::TID_W-1:0]        thread_id_i,
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output logic [trq_pkg::STATUS_W-1:0]     status_o,
  output logic [trq_pkg::TID_W-1:0]        result_id_o,
  output logic                             now_empty_o
);

  localparam int unsigned AW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam int unsigned SW = CW + 1;

  localparam logic [CW-1:0] CNT_FULL  = CW'(DEPTH);
  localparam logic [SW-1:0] SPAN      = SW'(DEPTH);
  localparam logic [AW-1:0] HEAD_LAST = AW'(DEPTH - 1);

  // store slot of a queue position, wrapping once past the end
  function automatic logic [AW-1:0] slot_of(input logic [AW-1:0] head,
                                            input logic [CW-1:0] pos);
    logic [SW-1:0] sum;
    sum = SW'(head) + SW'(pos);
    if (sum >= SPAN) begin
      sum = sum - SPAN;
    end
    return sum[AW-1:0];
  endfunction

  logic [trq_pkg::CMD_W-1:0]    cmd_q;
  logic [ID_BITS-1:0]           id_q, id_d;
  logic [ID_BITS+trq_pkg::TID_W-1:0] id_ext;
  logic [AW-1:0]                head_q, head_d;
  logic [CW-1:0]                count_q, count_d;
  logic [CW-1:0]                ptr_q, ptr_d;
  logic [CW-1:0]                ptr_next;
  logic [ID_BITS-1:0]           mem [DEPTH];
  logic [ID_BITS-1:0]           rdata_q;
  logic [AW-1:0]                raddr, waddr;
  logic [ID_BITS-1:0]           wdata;
  logic                         we;
  logic [trq_pkg::STATUS_W-1:0] res_status_q;
  logic [ID_BITS-1:0]           res_id_q;
  logic                         out_valid_q, out_valid_d;
  logic [trq_pkg::STATUS_W-1:0] out_status_q;
  logic [ID_BITS-1:0]           out_id_q;
  logic                         out_empty_q;
  logic [ID_BITS+trq_pkg::TID_W-1:0] res_ext;

  // incoming id kept in its low ID_BITS bits
  assign id_ext = {{ID_BITS{1'b0}}, thread_id_i};
  assign id_d   = id_ext[ID_BITS-1:0];

  assign ptr_next = ptr_q + CW'(1);

  // scan pointer, head and count updates
  always_comb begin
    ptr_d = ptr_q;
    if (ctrl_i.ptr_clr) begin
      ptr_d = '0;
    end else if (ctrl_i.ptr_inc) begin
      ptr_d = ptr_next;
    end
    head_d = head_q;
    if (ctrl_i.head_inc) begin
      head_d = (head_q == HEAD_LAST) ? '0 : head_q + AW'(1);
    end
    count_d = count_q;
    if (ctrl_i.cnt_inc) begin
      count_d = count_q + CW'(1);
    end else if (ctrl_i.cnt_dec) begin
      count_d = count_q - CW'(1);
    end
  end

  // store ports: read follows the next pointer so data lines up with ptr_q
  assign raddr = slot_of(head_q, ptr_d);
  assign waddr = ctrl_i.wr_enq ? slot_of(head_q, count_q) : slot_of(head_q, ptr_q - CW'(1));
  assign wdata = ctrl_i.wr_enq ? id_q : rdata_q;
  assign we    = ctrl_i.wr_enq | ctrl_i.wr_shift;

  // id store
  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_q <= mem[raddr];
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q      <= '0;
      count_q     <= '0;
      ptr_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      head_q      <= head_d;
      count_q     <= count_d;
      ptr_q       <= ptr_d;
      out_valid_q <= out_valid_d;
    end
  end

  // command capture and result registers
  always_ff @(posedge clk_i) begin
    if (ctrl_i.load) begin
      cmd_q <= command_i;
      id_q  <= id_d;
    end
    if (ctrl_i.res_wr) begin
      res_status_q <= ctrl_i.res_status;
      res_id_q     <= ctrl_i.res_take ? rdata_q : '0;
    end
    if (ctrl_i.out_load) begin
      out_status_q <= res_status_q;
      out_id_q     <= res_id_q;
      out_empty_q  <= (count_q == '0);
    end
  end

  // output word register
  always_comb begin
    out_valid_d = out_valid_q;
    if (ctrl_i.out_load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  assign res_ext     = {{trq_pkg::TID_W{1'b0}}, out_id_q};
  assign out_valid_o = out_valid_q;
  assign status_o    = out_status_q;
  assign result_id_o = res_ext[trq_pkg::TID_W-1:0];
  assign now_empty_o = out_empty_q;

  // status back to the controller
  assign stat_o.command  = cmd_q;
  assign stat_o.full     = (count_q == CNT_FULL);
  assign stat_o.empty    = (count_q == '0);
  assign stat_o.match    = (rdata_q == id_q);
  assign stat_o.at_end   = (ptr_q == count_q);
  assign stat_o.last     = (ptr_next == count_q);
  assign stat_o.at_head  = (ptr_q == '0);
  assign stat_o.out_busy = out_valid_q & ~out_ready_i;

`ifndef NO_ASSERTIONS
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_FULL) else $error("entry count beyond capacity");

  a_no_enq_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl_i.wr_enq |-> count_q != CNT_FULL) else $error("write into full queue");

  a_head_with_dec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl_i.head_inc |-> ctrl_i.cnt_dec && count_q != '0)
    else $error("head moved without dropping an entry");

  a_out_no_overrun: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl_i.out_load |-> !(out_valid_q && !out_ready_i))
    else $error("output word overwritten");
`endif

endmodule

`default_nettype wire

// ===== src/trq_ctrl.sv =====
// ----------------------------------------------------------------------------
// trq_ctrl
// Controller of the thread ready queue: sequences enqueue, dequeue, the
// search scan, the compaction shift and the hand-off to the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module trq_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cmd_valid_i,
  output logic               cmd_ready_o,
  input  trq_pkg::trq_stat_t stat_i,
  output trq_pkg::trq_ctrl_t ctrl_o
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_EXEC  = 3'd1;
  localparam logic [2:0] S_SCAN  = 3'd2;
  localparam logic [2:0] S_SHIFT = 3'd3;
  localparam logic [2:0] S_NEXT  = 3'd4;
  localparam logic [2:0] S_DONE  = 3'd5;

  logic [2:0] state_q, state_d;

  // next state and datapath commands
  always_comb begin
    state_d     = state_q;
    ctrl_o      = '0;
    cmd_ready_o = 1'b0;
    case (state_q)
      S_IDLE: begin
        cmd_ready_o = 1'b1;
        if (cmd_valid_i) begin
          ctrl_o.load    = 1'b1;
          ctrl_o.ptr_clr = 1'b1;
          state_d        = S_EXEC;
        end
      end
      S_EXEC: begin
        if (stat_i.command == trq_pkg::CMD_ENQ) begin
          ctrl_o.res_wr = 1'b1;
          if (stat_i.full) begin
            ctrl_o.res_status = trq_pkg::ST_FULL;
          end else begin
            ctrl_o.res_status = trq_pkg::ST_OK;
            ctrl_o.wr_enq     = 1'b1;
            ctrl_o.cnt_inc    = 1'b1;
          end
          state_d = S_DONE;
        end else if (stat_i.empty) begin
          ctrl_o.res_wr     = 1'b1;
          ctrl_o.res_status = trq_pkg::ST_EMPTY;
          state_d           = S_DONE;
        end else if (stat_i.command == trq_pkg::CMD_DEQ) begin
          ctrl_o.res_wr     = 1'b1;
          ctrl_o.res_take   = 1'b1;
          ctrl_o.res_status = trq_pkg::ST_OK;
          ctrl_o.head_inc   = 1'b1;
          ctrl_o.cnt_dec    = 1'b1;
          state_d           = S_DONE;
        end else begin
          state_d = S_SCAN;
        end
      end
      // one entry compared per cycle, from the head
      S_SCAN: begin
        if (stat_i.at_end) begin
          ctrl_o.res_wr     = 1'b1;
          ctrl_o.res_status = trq_pkg::ST_NOTFOUND;
          state_d           = S_DONE;
        end else if (stat_i.match) begin
          if (stat_i.command == trq_pkg::CMD_REM) begin
            ctrl_o.res_wr     = 1'b1;
            ctrl_o.res_take   = 1'b1;
            ctrl_o.res_status = trq_pkg::ST_OK;
            ctrl_o.cnt_dec    = 1'b1;
            if (stat_i.at_head) begin
              ctrl_o.head_inc = 1'b1;
              state_d         = S_DONE;
            end else if (stat_i.last) begin
              state_d = S_DONE;
            end else begin
              ctrl_o.ptr_inc = 1'b1;
              state_d        = S_SHIFT;
            end
          end else begin
            // successor wraps from the tail to the head
            if (stat_i.last) begin
              ctrl_o.ptr_clr = 1'b1;
            end else begin
              ctrl_o.ptr_inc = 1'b1;
            end
            state_d = S_NEXT;
          end
        end else begin
          ctrl_o.ptr_inc = 1'b1;
        end
      end
      // close the gap: each entry moves one place toward the head
      S_SHIFT: begin
        ctrl_o.wr_shift = 1'b1;
        if (stat_i.at_end) begin
          state_d = S_DONE;
        end else begin
          ctrl_o.ptr_inc = 1'b1;
        end
      end
      S_NEXT: begin
        ctrl_o.res_wr     = 1'b1;
        ctrl_o.res_take   = 1'b1;
        ctrl_o.res_status = trq_pkg::ST_OK;
        state_d           = S_DONE;
      end
      S_DONE: begin
        if (!stat_i.out_busy) begin
          ctrl_o.out_load = 1'b1;
          state_d         = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

`ifndef NO_ASSERTIONS
  a_ready_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_ready_o |-> !ctrl_o.wr_shift && !ctrl_o.res_wr)
    else $error("command taken while a word is in work");

  a_shift_after_rem: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl_o.wr_shift |-> stat_i.command == trq_pkg::CMD_REM)
    else $error("compaction outside a remove");

  a_load_to_exec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl_o.load |=> state_q == S_EXEC) else $error("accepted word not executed");
`endif

endmodule

`default_nettype wire

// ===== src/thread_ready_queue.sv =====
// ----------------------------------------------------------------------------
// thread_ready_queue
// Circular ready queue of thread ids with enqueue, dequeue, remove by id
// and successor lookup; one result word per command word.
// ----------------------------------------------------------------------------
// A command word is accepted only while no other command is in work; the
// result sits in an output register, so the next command can be taken while
// the previous result waits. Enqueue, dequeue and commands on an empty queue
// are decided in the execute state and then loaded into the output register.
// Remove and next-after-id scan the id store from the head one entry per
// cycle through its single read port, and a remove then moves every later
// entry up one place at one entry per cycle.
// The id store holds no reset value; only written entries are ever read.
`default_nettype none

module thread_ready_queue #(
  parameter int unsigned DEPTH   = 16,
  parameter int unsigned ID_BITS = 8
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  trq_cmd_if.sink       cmd_i,
  trq_res_if.source     res_o
);

  trq_pkg::trq_ctrl_t ctrl;
  trq_pkg::trq_stat_t stat;
  logic               cmd_ready;

  assign cmd_i.ready = cmd_ready;

  // sequencing
  trq_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (cmd_i.valid),
    .cmd_ready_o (cmd_ready),
    .stat_i      (stat),
    .ctrl_o      (ctrl)
  );

  // store, pointers and result register
  trq_dp #(
    .DEPTH   (DEPTH),
    .ID_BITS (ID_BITS)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ctrl_i      (ctrl),
    .stat_o      (stat),
    .command_i   (cmd_i.command),
    .thread_id_i (cmd_i.thread_id),
    .out_valid_o (res_o.valid),
    .out_ready_i (res_o.ready),
    .status_o    (res_o.status),
    .result_id_o (res_o.result_id),
    .now_empty_o (res_o.now_empty)
  );

endmodule

`default_nettype wire
